[sv/first_fit_block_allocator_unit_assert.svh]
// Assertion macros shared by the allocator RTL files.
// Each macro expands to one labelled concurrent assertion on the rising clock edge.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ffba_pkg.sv]
// Package for the first-fit block allocator: sizes, codes, payload and
// controller/datapath interface structs. No dependencies.
`default_nettype none

package ffba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int ADDR_BITS  = 32;

  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int REQ_W      = 32;
  localparam int HDR_W      = 8;
  localparam int TYPE_W     = 32;
  localparam int WIDE_W     = 64;
  localparam int OUT_ADDR_W = 32;
  localparam int STATUS_W   = 3;
  localparam int CMP_W      = ((ADDR_BITS > REQ_W) ? ADDR_BITS : REQ_W) + 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Highest address value; bases at or above it are refused
  localparam logic [WIDE_W-1:0] ADDR_LIM = (WIDE_W'(1) << ADDR_BITS) - WIDE_W'(1);

  localparam logic [HDR_W-1:0]  HDR_RESET   = HDR_W'(20);
  localparam logic [TYPE_W-1:0] TYPE_RESET  = TYPE_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVAILABLE_TYPE = 1'b1;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic                opcode;
    logic [WIDE_W-1:0]   region_base;
    logic [WIDE_W-1:0]   region_length;
    logic [TYPE_W-1:0]   region_type;
    logic [REQ_W-1:0]    request_size;
  } ffba_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_ADDR_W-1:0] address;
  } ffba_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // capture input item, clear scan position
    logic add_commit;   // settle an add item
    logic scan_inc;     // advance to next table entry
    logic shift_start;  // load shift pointer with block count
    logic shift_step;   // move one entry up by one place
    logic split_write;  // insert the split-off free block
    logic mark;         // mark found block used, record its address
    logic res_nofit;    // record no-fit result
    logic out_load;     // move result into output register
  } ffba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;
    logic hit;
    logic split_want;
    logic shift_done;
  } ffba_sts_t;

endpackage

`default_nettype wire

[sv/first_fit_block_allocator_unit.sv]
// Top level of the first-fit block allocator: controller plus datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_dp.
//
// One item at a time, one result per item. An add item goes from acceptance
// through the add state to the result state. An allocate item scans the table
// from position 0 for the first fitting block; a block handed out whole is marked
// directly, while a split first shifts the entries behind it up, inserts the
// split-off free block and then marks. A request that fits nowhere ends the scan
// at the block count. The pace is set by the single-ported block table: the scan
// reads one entry per cycle and the insert moves one entry per cycle. The insert
// only moves the entries behind the hit, so the longest item is a split with
// MAX_BLOCKS - 1 blocks held. A result that is still waiting at the output delays
// the next one by as long as it waits. The next item is accepted as soon as the
// result sits in the output register, even while that result waits to be taken.
// Table entries have no reset; only entries below the block count are ever read.
`default_nettype none

module first_fit_block_allocator_unit import ffba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ffba_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ffba_out_t             out_data
);

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_data.opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

[sv/ffba_dp.sv]
// Allocator datapath: configuration registers, block table, counters and
// result registers. Depends on ffba_pkg and the assertion macro header.
`default_nettype none
`include "first_fit_block_allocator_unit_assert.svh"

module ffba_dp import ffba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  ffba_in_t              in_data,
  output ffba_out_t             out_data,
  input  ffba_cmd_t             cmd,
  output ffba_sts_t             sts
);

  logic [HDR_W-1:0]     hdr_r;
  logic [TYPE_W-1:0]    avail_r;
  ffba_in_t             item_r;

  logic [ADDR_BITS-1:0] blk_addr_r [MAX_BLOCKS];
  logic [ADDR_BITS-1:0] blk_size_r [MAX_BLOCKS];
  logic                 blk_used_r [MAX_BLOCKS];

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     scan_r;
  logic [CNT_W-1:0]     shift_r;
  logic                 split_r;
  logic [STATUS_W-1:0]  res_status_r;
  logic [OUT_ADDR_W-1:0] res_addr_r;
  ffba_out_t            out_r;

  logic [CNT_W-1:0]     scan_p1;
  logic [CNT_W-1:0]     shift_m1;
  logic [IDX_W-1:0]     rd_idx;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [ADDR_BITS-1:0] rd_size;
  logic                 rd_used;

  logic                 full;
  logic                 base_zero;
  logic [WIDE_W-1:0]    hdr_wide;
  logic                 add_ok;
  logic [WIDE_W-1:0]    add_size_wide;
  logic [ADDR_BITS-1:0] add_size;
  logic [ADDR_BITS-1:0] add_start;
  logic [ADDR_BITS-1:0] add_addr;
  logic [STATUS_W-1:0]  add_code;

  logic [CMP_W-1:0]     req_c;
  logic [CMP_W-1:0]     size_c;
  logic [CMP_W-1:0]     hdr_c;
  logic [ADDR_BITS-1:0] req_a;
  logic [ADDR_BITS-1:0] hdr_a;
  logic [ADDR_BITS-1:0] new_addr;
  logic [ADDR_BITS-1:0] new_size;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [ADDR_BITS-1:0] wr_size;
  logic                 wr_used;

  // Single table read port: shift pointer while moving entries, else scan position
  assign scan_p1  = scan_r + CNT_W'(1);
  assign shift_m1 = shift_r - CNT_W'(1);
  assign rd_idx   = cmd.shift_step ? shift_m1[IDX_W-1:0] : scan_r[IDX_W-1:0];
  assign rd_addr  = blk_addr_r[rd_idx];
  assign rd_size  = blk_size_r[rd_idx];
  assign rd_used  = blk_used_r[rd_idx];

  assign full = count_r >= CNT_W'(MAX_BLOCKS);

  // Add path
  assign base_zero     = item_r.region_base == '0;
  assign hdr_wide      = WIDE_W'(hdr_r);
  assign add_ok        = (item_r.region_type == avail_r) &&
                         (item_r.region_length > hdr_wide) &&
                         (item_r.region_base < ADDR_LIM);
  assign add_size_wide = item_r.region_length - hdr_wide - WIDE_W'(base_zero);
  assign add_size      = (add_size_wide > ADDR_LIM) ? '1 : add_size_wide[ADDR_BITS-1:0];
  // A zero base moves up to one
  assign add_start     = base_zero ? ADDR_BITS'(1) : item_r.region_base[ADDR_BITS-1:0];
  assign add_addr      = add_start + ADDR_BITS'(hdr_r);

  always_comb begin
    if (!add_ok) begin
      add_code = ST_REJECTED;
    end else if (full) begin
      add_code = ST_FULL;
    end else begin
      add_code = ST_ADDED;
    end
  end

  // Allocate path
  assign req_c    = CMP_W'(item_r.request_size);
  assign size_c   = CMP_W'(rd_size);
  assign hdr_c    = CMP_W'(hdr_r);
  assign req_a    = ADDR_BITS'(item_r.request_size);
  assign hdr_a    = ADDR_BITS'(hdr_r);
  assign new_addr = rd_addr + req_a + hdr_a;
  assign new_size = rd_size - req_a - hdr_a;

  assign sts.scan_end   = scan_r >= count_r;
  assign sts.hit        = !rd_used && (size_c >= req_c);
  assign sts.split_want = (size_c > (req_c + hdr_c)) && !full;
  assign sts.shift_done = shift_r <= scan_p1;

  // Table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = count_r[IDX_W-1:0];
    wr_addr = add_addr;
    wr_size = add_size;
    wr_used = 1'b0;
    if (cmd.add_commit) begin
      wr_en = add_code == ST_ADDED;
    end else if (cmd.shift_step) begin
      wr_en   = 1'b1;
      wr_idx  = shift_r[IDX_W-1:0];
      wr_addr = rd_addr;
      wr_size = rd_size;
      wr_used = rd_used;
    end else if (cmd.split_write) begin
      wr_en   = 1'b1;
      wr_idx  = scan_p1[IDX_W-1:0];
      wr_addr = new_addr;
      wr_size = new_size;
    end else if (cmd.mark) begin
      wr_en   = 1'b1;
      wr_idx  = scan_r[IDX_W-1:0];
      wr_addr = rd_addr;
      wr_size = split_r ? req_a : rd_size;
      wr_used = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_addr_r[wr_idx] <= wr_addr;
      blk_size_r[wr_idx] <= wr_size;
      blk_used_r[wr_idx] <= wr_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r   <= HDR_RESET;
      avail_r <= TYPE_RESET;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER_BYTES:   hdr_r   <= cfg_wdata[HDR_W-1:0];
          CFG_AVAILABLE_TYPE: avail_r <= cfg_wdata[TYPE_W-1:0];
          default: ;
        endcase
      end
      if ((cmd.add_commit && (add_code == ST_ADDED)) || cmd.split_write) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r  <= in_data;
      scan_r  <= '0;
      split_r <= 1'b0;
    end
    if (cmd.scan_inc) begin
      scan_r <= scan_p1;
    end
    if (cmd.shift_start) begin
      shift_r <= count_r;
    end
    if (cmd.shift_step) begin
      shift_r <= shift_m1;
    end
    if (cmd.split_write) begin
      split_r <= 1'b1;
    end
    if (cmd.add_commit) begin
      res_status_r <= add_code;
      res_addr_r   <= '0;
    end
    if (cmd.mark) begin
      res_status_r <= ST_ALLOCATED;
      res_addr_r   <= OUT_ADDR_W'(rd_addr);
    end
    if (cmd.res_nofit) begin
      res_status_r <= ST_NO_FIT;
      res_addr_r   <= '0;
    end
    if (cmd.out_load) begin
      out_r.status  <= res_status_r;
      out_r.address <= res_addr_r;
    end
  end

  assign out_data = out_r;

  `FFBA_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_BLOCKS), "block count beyond table depth")
  `FFBA_ASSERT_NOW(a_split_room, clk, rst_n, cmd.split_write, !full && (scan_r < count_r), "split insert without room")
  `FFBA_ASSERT_NOW(a_shift_range, clk, rst_n, cmd.shift_step, (shift_r <= count_r) && (shift_r > scan_p1), "shift pointer out of range")
  `FFBA_ASSERT_NEXT(a_add_grows, clk, rst_n, cmd.add_commit && (add_code == ST_ADDED), count_r == $past(count_r) + CNT_W'(1), "added block not counted")

endmodule

`default_nettype wire

[sv/ffba_ctrl.sv]
// Allocator controller: sequences add, first-fit scan, insertion shift and
// result hand-off. Depends on ffba_pkg and the assertion macro header.
`default_nettype none
`include "first_fit_block_allocator_unit_assert.svh"

module ffba_ctrl import ffba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_opcode,
  output logic      out_valid,
  input  logic      out_ready,
  output ffba_cmd_t cmd,
  input  ffba_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_SHIFT,
    S_SPLIT,
    S_MARK,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_opcode == OP_ALLOC) ? S_SCAN : S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_commit = 1'b1;
        state_nxt      = S_RESP;
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          cmd.res_nofit = 1'b1;
          state_nxt     = S_RESP;
        end else if (sts.hit) begin
          if (sts.split_want) begin
            cmd.shift_start = 1'b1;
            state_nxt       = S_SHIFT;
          end else begin
            state_nxt = S_MARK;
          end
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = S_SPLIT;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_SPLIT: begin
        cmd.split_write = 1'b1;
        state_nxt       = S_MARK;
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // Hold the result until the output register can take it
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `FFBA_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !cmd.out_load, "pending result overwritten")
  `FFBA_ASSERT_NEXT(a_split_then_mark, clk, rst_n, cmd.split_write, state_r == S_MARK, "split not followed by mark")
  `FFBA_ASSERT_NOW(a_busy_no_accept, clk, rst_n, state_r != S_IDLE, !in_ready, "item taken while busy")

endmodule

`default_nettype wire
